// ===== rtl/tpp_pkg.sv =====
// Shared types, constants and arithmetic helpers for the triangle projection block.
package tpp_pkg;

  localparam int NUM_VTX      = 3;
  localparam int NUM_LANES    = 9;   // three vertices times x, y, z
  localparam int FRAC_BITS    = 16;
  localparam int DIV_BITS     = 32;  // quotient bits produced by the divider
  localparam int DIV_STEP     = 2;   // quotient bits per pipeline stage
  localparam int DIV_STAGES   = DIV_BITS / DIV_STEP;
  localparam int CFG_IDX_W    = 8;
  localparam int HALF_W       = 13;

  // 1/3 as ceil(2^34 / 3) = 2^32 + AVG_RECIP_LO, exact for sums below 2^33
  localparam logic [30:0] AVG_RECIP_LO = 31'h5555_5556;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [47:0] wide_t;

  localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SCALE     = 8'd0,
    CFG_Y_SCALE     = 8'd1,
    CFG_Z_SCALE     = 8'd2,
    CFG_Z_OFFSET    = 8'd3,
    CFG_HALF_WIDTH  = 8'd4,
    CFG_HALF_HEIGHT = 8'd5
  } cfg_idx_t;

  typedef struct packed {
    q16_t              x_scale;
    q16_t              y_scale;
    q16_t              z_scale;
    q16_t              z_offset;
    logic [HALF_W-1:0] half_w;
    logic [HALF_W-1:0] half_h;
  } cfg_t;

  // One divider lane: remainder, numerator shifting out / quotient shifting in
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] nq;
    logic [31:0] den;
    logic        neg;
    logic        ovf;
    logic        zero;
    q16_t        clip;
  } lane_t;

  // Depth sum magnitude, its partial product with the reciprocal, quotient
  typedef struct packed {
    logic [32:0] mag;
    logic [63:0] prod;
    logic [31:0] quo;
    logic        neg;
  } avg_t;

  function automatic q16_t sat48(input wide_t v);
    q16_t r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = Q16_MAX;
    end else if (v < -48'sh0000_8000_0000) begin
      r = Q16_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic lane_t lane_step(input lane_t l);
    lane_t       o;
    logic [32:0] t;
    o = l;
    t = {l.rem, l.nq[31]};
    if (t >= {1'b0, l.den}) begin
      o.rem = 32'(t - {1'b0, l.den});
      o.nq  = {l.nq[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.nq  = {l.nq[30:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== rtl/tpp_if.sv =====
// Channel interfaces: triangle input, projected result, configuration write.
interface tpp_in_if;
  logic               valid;
  logic               ready;
  tpp_pkg::q16_t      v0_x, v0_y, v0_z;
  tpp_pkg::q16_t      v1_x, v1_y, v1_z;
  tpp_pkg::q16_t      v2_x, v2_y, v2_z;
  modport source(output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                 input ready);
  modport sink(input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
               output ready);
endinterface

interface tpp_out_if;
  logic               valid;
  logic               ready;
  tpp_pkg::q16_t      s0_x, s0_y, s0_depth;
  tpp_pkg::q16_t      s1_x, s1_y, s1_depth;
  tpp_pkg::q16_t      s2_x, s2_y, s2_depth;
  tpp_pkg::q16_t      avg_depth;
  logic [2:0]         w_zero_mask;
  modport source(output valid, s0_x, s0_y, s0_depth, s1_x, s1_y, s1_depth,
                 s2_x, s2_y, s2_depth, avg_depth, w_zero_mask, input ready);
  modport sink(input valid, s0_x, s0_y, s0_depth, s1_x, s1_y, s1_depth,
               s2_x, s2_y, s2_depth, avg_depth, w_zero_mask, output ready);
endinterface

interface tpp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tpp_pkg::CFG_IDX_W-1:0]     index;
  logic [31:0]                       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/triangle_perspective_projection_top.sv =====
// Top level of the triangle perspective projection and viewport pipeline.
// Usage:
//   in_ch  : one item is a triangle of three view-space vertices, Q16.16.
//   out_ch : one item per triangle: screen x, flipped screen y and projected
//            depth per vertex, the mean view-space depth and a mask of the
//            vertices whose w was zero (divide skipped, clip value passed).
//   cfg_ch : register writes (index, data); always ready, write only while
//            the pipeline is empty.
// The pipe has 3 clip stages, 16 divider stages (two quotient bits per
// stage) and 3 viewport/output stages. Throughput is one triangle per cycle
// while out_ch is not stalled.
// A synchronous low rst_n clears all stage valid bits and loads the register
// defaults (unit scales, zero offset, 320 x 240 half window).
// When out_ch stalls with a result held, every stage freezes, bubbles
// included, and in_ch.ready drops; the pipe advances whenever the output
// register is empty or being drained, so a stall costs no items and
// repeats none.
module triangle_perspective_projection_top (
  input  logic  clk,
  input  logic  rst_n,
  tpp_in_if.sink     in_ch,
  tpp_out_if.source  out_ch,
  tpp_cfg_if.sink    cfg_ch
);

  tpp_pkg::cfg_t   cfg_r;
  logic            en;
  tpp_pkg::q16_t   vtx [3][3];

  logic            clip_valid;
  tpp_pkg::lane_t  clip_lanes [tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t   clip_avg;
  logic            div_valid;
  tpp_pkg::lane_t  div_lanes [tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t   div_avg;
  logic            res_valid;
  tpp_pkg::q16_t   res [tpp_pkg::NUM_LANES];
  tpp_pkg::q16_t   res_avg;
  logic [2:0]      res_mask;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale  <= 32'sd65536;
      cfg_r.y_scale  <= 32'sd65536;
      cfg_r.z_scale  <= 32'sd65536;
      cfg_r.z_offset <= 32'sd0;
      cfg_r.half_w   <= 13'd320;
      cfg_r.half_h   <= 13'd240;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tpp_pkg::CFG_X_SCALE:     cfg_r.x_scale  <= cfg_ch.data;
        tpp_pkg::CFG_Y_SCALE:     cfg_r.y_scale  <= cfg_ch.data;
        tpp_pkg::CFG_Z_SCALE:     cfg_r.z_scale  <= cfg_ch.data;
        tpp_pkg::CFG_Z_OFFSET:    cfg_r.z_offset <= cfg_ch.data;
        tpp_pkg::CFG_HALF_WIDTH:  cfg_r.half_w   <= cfg_ch.data[tpp_pkg::HALF_W-1:0];
        tpp_pkg::CFG_HALF_HEIGHT: cfg_r.half_h   <= cfg_ch.data[tpp_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: output register empty or being taken
  assign en          = out_ch.ready || !res_valid;
  assign in_ch.ready = en;

  assign vtx[0][0] = in_ch.v0_x;
  assign vtx[0][1] = in_ch.v0_y;
  assign vtx[0][2] = in_ch.v0_z;
  assign vtx[1][0] = in_ch.v1_x;
  assign vtx[1][1] = in_ch.v1_y;
  assign vtx[1][2] = in_ch.v1_z;
  assign vtx[2][0] = in_ch.v2_x;
  assign vtx[2][1] = in_ch.v2_y;
  assign vtx[2][2] = in_ch.v2_z;

  tpp_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_ch.valid),
    .vtx        (vtx),
    .cfg        (cfg_r),
    .lane_valid (clip_valid),
    .lanes      (clip_lanes),
    .avg        (clip_avg)
  );

  tpp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (clip_valid),
    .lanes_in  (clip_lanes),
    .avg_in    (clip_avg),
    .out_valid (div_valid),
    .lanes_out (div_lanes),
    .avg_out   (div_avg)
  );

  tpp_view u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .lanes     (div_lanes),
    .avg       (div_avg),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .res_avg   (res_avg),
    .res_mask  (res_mask)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.s0_x        = res[0];
  assign out_ch.s0_y        = res[1];
  assign out_ch.s0_depth    = res[2];
  assign out_ch.s1_x        = res[3];
  assign out_ch.s1_y        = res[4];
  assign out_ch.s1_depth    = res[5];
  assign out_ch.s2_x        = res[6];
  assign out_ch.s2_y        = res[7];
  assign out_ch.s2_depth    = res[8];
  assign out_ch.avg_depth   = res_avg;
  assign out_ch.w_zero_mask = res_mask;

endmodule

// ===== rtl/tpp_clip.sv =====
// Clip-space scaling, saturation and divider operand preparation (three stages).
module tpp_clip (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tpp_pkg::q16_t       vtx [3][3],
  input  tpp_pkg::cfg_t       cfg,
  output logic                lane_valid,
  output tpp_pkg::lane_t      lanes [tpp_pkg::NUM_LANES],
  output tpp_pkg::avg_t       avg
);

  logic                 va_r, vb_r, vc_r;
  logic signed [63:0]   prod_r [3][3];
  tpp_pkg::q16_t        za_r   [3];
  tpp_pkg::q16_t        clip_r [3][3];
  tpp_pkg::q16_t        clip_nxt [3][3];
  tpp_pkg::q16_t        zb_r   [3];
  logic signed [33:0]   zsum_r, zsum_nxt;
  tpp_pkg::lane_t       lane_r [tpp_pkg::NUM_LANES];
  tpp_pkg::lane_t       lane_nxt [tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t        avg_r, avg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // clip = floor(scale * coord / 2^16), z also gets the offset
  always_comb begin
    tpp_pkg::wide_t sh;
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        sh = 48'(prod_r[v][c] >>> tpp_pkg::FRAC_BITS);
        if (c == 2) begin
          sh = sh + 48'(cfg.z_offset);
        end
        clip_nxt[v][c] = tpp_pkg::sat48(sh);
      end
    end
    zsum_nxt = 34'(za_r[0]) + 34'(za_r[1]) + 34'(za_r[2]);
  end

  // magnitudes for the divider; quotient over 32 bits is flagged up front
  always_comb begin
    logic [31:0] mag;
    logic [31:0] den;
    logic [33:0] amag;
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        mag = clip_r[v][c][31] ? 32'(-clip_r[v][c]) : clip_r[v][c];
        den = zb_r[v][31] ? 32'(-zb_r[v]) : zb_r[v];
        lane_nxt[v*3+c].rem  = {16'd0, mag[31:16]};
        lane_nxt[v*3+c].nq   = {mag[15:0], 16'd0};
        lane_nxt[v*3+c].den  = den;
        lane_nxt[v*3+c].neg  = clip_r[v][c][31] ^ zb_r[v][31];
        lane_nxt[v*3+c].ovf  = {16'd0, mag[31:16]} >= den;
        lane_nxt[v*3+c].zero = (zb_r[v] == '0);
        lane_nxt[v*3+c].clip = clip_r[v][c];
      end
    end
    // |sum| never exceeds 3 * 2^31, so 33 bits hold it
    amag         = zsum_r[33] ? 34'(-zsum_r) : zsum_r;
    avg_nxt.mag  = amag[32:0];
    avg_nxt.prod = 64'd0;
    avg_nxt.quo  = 32'd0;
    avg_nxt.neg  = zsum_r[33];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        prod_r[v][0] <= vtx[v][0] * cfg.x_scale;
        prod_r[v][1] <= vtx[v][1] * cfg.y_scale;
        prod_r[v][2] <= vtx[v][2] * cfg.z_scale;
        za_r[v]      <= vtx[v][2];
        zb_r[v]      <= za_r[v];
        for (int c = 0; c < 3; c++) begin
          clip_r[v][c] <= clip_nxt[v][c];
        end
      end
      zsum_r <= zsum_nxt;
      for (int l = 0; l < tpp_pkg::NUM_LANES; l++) begin
        lane_r[l] <= lane_nxt[l];
      end
      avg_r <= avg_nxt;
    end
  end

  assign lane_valid = vc_r;
  assign lanes      = lane_r;
  assign avg        = avg_r;

endmodule

// ===== rtl/tpp_div.sv =====
// Pipelined restoring divider for nine lanes; depth sum over three by reciprocal multiply.
module tpp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tpp_pkg::lane_t      lanes_in  [tpp_pkg::NUM_LANES],
  input  tpp_pkg::avg_t       avg_in,
  output logic                out_valid,
  output tpp_pkg::lane_t      lanes_out [tpp_pkg::NUM_LANES],
  output tpp_pkg::avg_t       avg_out
);

  localparam int S = tpp_pkg::DIV_STAGES;

  logic           v_r    [S];
  tpp_pkg::lane_t st_r   [S][tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t  ast_r  [S];
  tpp_pkg::lane_t src    [S][tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t  asrc   [S];
  logic           vsrc   [S];
  tpp_pkg::lane_t st_nxt [S][tpp_pkg::NUM_LANES];
  tpp_pkg::avg_t  ast_nxt[S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign src[s]  = lanes_in;
      assign asrc[s] = avg_in;
      assign vsrc[s] = in_valid;
    end else begin : g_next
      assign src[s]  = st_r[s-1];
      assign asrc[s] = ast_r[s-1];
      assign vsrc[s] = v_r[s-1];
    end

    always_comb begin
      tpp_pkg::lane_t l;
      tpp_pkg::avg_t  a;
      logic [65:0]    acc;
      for (int k = 0; k < tpp_pkg::NUM_LANES; k++) begin
        l = src[s][k];
        for (int j = 0; j < tpp_pkg::DIV_STEP; j++) begin
          l = tpp_pkg::lane_step(l);
        end
        st_nxt[s][k] = l;
      end
      // sum / 3: low partial product first, then add mag * 2^32 and drop 34 bits
      a   = asrc[s];
      acc = {1'b0, a.mag, 32'd0} + {2'b00, a.prod};
      if (s == 0) begin
        a.prod = {31'd0, a.mag} * {33'd0, tpp_pkg::AVG_RECIP_LO};
      end else if (s == 1) begin
        a.quo = acc[65:34];
      end
      ast_nxt[s] = a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vsrc[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < tpp_pkg::NUM_LANES; k++) begin
          st_r[s][k] <= st_nxt[s][k];
        end
        ast_r[s] <= ast_nxt[s];
      end
    end
  end

  assign out_valid = v_r[S-1];
  assign lanes_out = st_r[S-1];
  assign avg_out   = ast_r[S-1];

endmodule

// ===== rtl/tpp_view.sv =====
// Quotient saturation, viewport mapping and the output register (three stages).
module tpp_view (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tpp_pkg::lane_t      lanes [tpp_pkg::NUM_LANES],
  input  tpp_pkg::avg_t       avg,
  input  tpp_pkg::cfg_t       cfg,
  output logic                res_valid,
  output tpp_pkg::q16_t       res [tpp_pkg::NUM_LANES],
  output tpp_pkg::q16_t       res_avg,
  output logic [2:0]          res_mask
);

  logic                 vd_r, ve_r, vf_r;
  tpp_pkg::q16_t        ndc_r [tpp_pkg::NUM_LANES];
  tpp_pkg::q16_t        ndc_nxt [tpp_pkg::NUM_LANES];
  tpp_pkg::q16_t        avgd_r, avgd_nxt, avge_r;
  logic [2:0]           maskd_r, maskd_nxt, maske_r;
  logic signed [45:0]   px_r [3];
  logic signed [45:0]   py_r [3];
  tpp_pkg::q16_t        dz_r [3];
  tpp_pkg::q16_t        res_r [tpp_pkg::NUM_LANES];
  tpp_pkg::q16_t        res_nxt [tpp_pkg::NUM_LANES];
  tpp_pkg::q16_t        avgf_r;
  logic [2:0]           maskf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      vd_r <= in_valid;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  // signed, saturated quotient; zero w passes the clip value through
  always_comb begin
    logic [31:0] q;
    logic [31:0] aq;
    for (int l = 0; l < tpp_pkg::NUM_LANES; l++) begin
      q = lanes[l].nq;
      if (lanes[l].zero) begin
        ndc_nxt[l] = lanes[l].clip;
      end else if (lanes[l].ovf) begin
        ndc_nxt[l] = lanes[l].neg ? tpp_pkg::Q16_MIN : tpp_pkg::Q16_MAX;
      end else if (lanes[l].neg) begin
        ndc_nxt[l] = (q > 32'h8000_0000) ? tpp_pkg::Q16_MIN : 32'(-q);
      end else begin
        ndc_nxt[l] = (q > 32'h7FFF_FFFF) ? tpp_pkg::Q16_MAX : q;
      end
    end
    for (int v = 0; v < 3; v++) begin
      maskd_nxt[v] = lanes[v*3].zero;
    end
    aq       = avg.quo;
    avgd_nxt = avg.neg ? 32'(-aq) : aq;
  end

  // screen = ndc*half + half*2^16, y flipped
  always_comb begin
    tpp_pkg::wide_t hx;
    tpp_pkg::wide_t hy;
    hx = 48'({cfg.half_w, 16'd0});
    hy = 48'({cfg.half_h, 16'd0});
    for (int v = 0; v < 3; v++) begin
      res_nxt[v*3]   = tpp_pkg::sat48(48'(px_r[v]) + hx);
      res_nxt[v*3+1] = tpp_pkg::sat48(hy - 48'(py_r[v]));
      res_nxt[v*3+2] = dz_r[v];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < tpp_pkg::NUM_LANES; l++) begin
        ndc_r[l] <= ndc_nxt[l];
        res_r[l] <= res_nxt[l];
      end
      avgd_r  <= avgd_nxt;
      maskd_r <= maskd_nxt;
      for (int v = 0; v < 3; v++) begin
        px_r[v] <= ndc_r[v*3]   * $signed({1'b0, cfg.half_w});
        py_r[v] <= ndc_r[v*3+1] * $signed({1'b0, cfg.half_h});
        dz_r[v] <= ndc_r[v*3+2];
      end
      avge_r  <= avgd_r;
      maske_r <= maskd_r;
      avgf_r  <= avge_r;
      maskf_r <= maske_r;
    end
  end

  assign res_valid = vf_r;
  assign res       = res_r;
  assign res_avg   = avgf_r;
  assign res_mask  = maskf_r;

endmodule

// ===== bench/tpp_tb_if.sv =====
// Testbench note: channel interfaces are those of the RTL file rtl/tpp_if.sv.
`timescale 1ns / 1ps
package tpp_tb_types;

  typedef struct packed {
    tpp_pkg::q16_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
  } tri_t;

  typedef struct packed {
    tpp_pkg::q16_t s0_x, s0_y, s0_depth, s1_x, s1_y, s1_depth, s2_x, s2_y, s2_depth;
    tpp_pkg::q16_t avg_depth;
    logic [2:0]    w_zero_mask;
  } proj_t;
endpackage

// ===== bench/tpp_checker.sv =====
// Checker: predicts the projection of every accepted triangle and compares results.
`timescale 1ns / 1ps
module tpp_checker (
  input  logic      clk,
  input  logic      rst_n,
  tpp_in_if         in_ch,
  tpp_out_if        out_ch,
  tpp_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending,
  output int        seen_results,
  output int        seen_zero_w
);
  longint xs, ys, zs, zo, hw, hh;
  tpp_tb_types::proj_t projections_due[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor16(longint a);
    longint q;
    q = a / 65536;
    if (a % 65536 != 0 && a < 0) q -= 1;
    return q;
  endfunction

  // gives sx, sy, depth and the zero-w flag of one vertex
  function automatic void project(input tpp_pkg::q16_t px, py, pz,
                                  output tpp_pkg::q16_t sx, sy, sd, output bit wz);
    longint x, y, z, cx, cy, cz, nx, ny, nz;
    x = px; y = py; z = pz;
    cx = clamp32(floor16(xs * x));
    cy = clamp32(floor16(ys * y));
    cz = clamp32(floor16(zs * z) + zo);
    wz = (z == 0);
    if (!wz) begin
      nx = clamp32((cx * 65536) / z);
      ny = clamp32((cy * 65536) / z);
      nz = clamp32((cz * 65536) / z);
    end else begin
      nx = cx; ny = cy; nz = cz;
    end
    sx = tpp_pkg::q16_t'(clamp32(nx * hw + hw * 65536));
    sy = tpp_pkg::q16_t'(clamp32(-ny * hh + hh * 65536));
    sd = tpp_pkg::q16_t'(nz);
  endfunction

  function automatic tpp_tb_types::proj_t predict_projection(tpp_tb_types::tri_t t);
    tpp_tb_types::proj_t p;
    bit b0, b1, b2;
    longint zsum;
    project(t.v0_x, t.v0_y, t.v0_z, p.s0_x, p.s0_y, p.s0_depth, b0);
    project(t.v1_x, t.v1_y, t.v1_z, p.s1_x, p.s1_y, p.s1_depth, b1);
    project(t.v2_x, t.v2_y, t.v2_z, p.s2_x, p.s2_y, p.s2_depth, b2);
    zsum = longint'(t.v0_z) + longint'(t.v1_z) + longint'(t.v2_z);
    p.avg_depth = tpp_pkg::q16_t'(zsum / 3);
    p.w_zero_mask = {b2, b1, b0};
    return p;
  endfunction

  function automatic bit field_bad(input string name, input logic [31:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      $error("field %s: expected %0h actual %0h", name, exp_v, act_v);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    tpp_tb_types::tri_t t;
    tpp_tb_types::proj_t got, exp_p;
    bit bad;
    if (!rst_n) begin
      xs = 65536; ys = 65536; zs = 65536; zo = 0; hw = 320; hh = 240;
      projections_due.delete();
      fail_count = 0; seen_results = 0; seen_zero_w = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (tpp_pkg::cfg_idx_t'(cfg_ch.index))
          tpp_pkg::CFG_X_SCALE:     xs = tpp_pkg::q16_t'(cfg_ch.data);
          tpp_pkg::CFG_Y_SCALE:     ys = tpp_pkg::q16_t'(cfg_ch.data);
          tpp_pkg::CFG_Z_SCALE:     zs = tpp_pkg::q16_t'(cfg_ch.data);
          tpp_pkg::CFG_Z_OFFSET:    zo = tpp_pkg::q16_t'(cfg_ch.data);
          tpp_pkg::CFG_HALF_WIDTH:  hw = cfg_ch.data[tpp_pkg::HALF_W-1:0];
          tpp_pkg::CFG_HALF_HEIGHT: hh = cfg_ch.data[tpp_pkg::HALF_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        t = {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y, in_ch.v1_z,
             in_ch.v2_x, in_ch.v2_y, in_ch.v2_z};
        projections_due.push_back(predict_projection(t));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.s0_x, out_ch.s0_y, out_ch.s0_depth, out_ch.s1_x, out_ch.s1_y,
               out_ch.s1_depth, out_ch.s2_x, out_ch.s2_y, out_ch.s2_depth,
               out_ch.avg_depth, out_ch.w_zero_mask};
        seen_results++;
        if (got.w_zero_mask != 0) seen_zero_w++;
        if (projections_due.size() == 0) begin
          $error("result with no triangle outstanding");
          fail_count++;
        end else begin
          exp_p = projections_due.pop_front();
          bad = 0;
          bad |= field_bad("s0_x", exp_p.s0_x, got.s0_x);
          bad |= field_bad("s0_y", exp_p.s0_y, got.s0_y);
          bad |= field_bad("s0_depth", exp_p.s0_depth, got.s0_depth);
          bad |= field_bad("s1_x", exp_p.s1_x, got.s1_x);
          bad |= field_bad("s1_y", exp_p.s1_y, got.s1_y);
          bad |= field_bad("s1_depth", exp_p.s1_depth, got.s1_depth);
          bad |= field_bad("s2_x", exp_p.s2_x, got.s2_x);
          bad |= field_bad("s2_y", exp_p.s2_y, got.s2_y);
          bad |= field_bad("s2_depth", exp_p.s2_depth, got.s2_depth);
          bad |= field_bad("avg_depth", exp_p.avg_depth, got.avg_depth);
          bad |= field_bad("w_zero_mask", {29'd0, exp_p.w_zero_mask},
                           {29'd0, got.w_zero_mask});
          if (bad) fail_count++;
        end
      end
    end
    pending = projections_due.size();
  end
endmodule

// ===== bench/tb_triangle_perspective_projection_top.sv =====
// Top of the projection testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_triangle_perspective_projection_top;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, seen_results, seen_zero_w;
  int   idle_cycles = 0;
  int   sent = 0;
  bit   hold_off = 0;   // long receiver stall requested by stimulus

  tpp_in_if  in_ch();
  tpp_out_if out_ch();
  tpp_cfg_if cfg_ch();

  triangle_perspective_projection_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch));

  tpp_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .seen_results(seen_results),
    .seen_zero_w(seen_zero_w));

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random coordinate biased toward extremes, small values and zero
  function automatic tpp_pkg::q16_t rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4: return tpp_pkg::q16_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5, 6: return tpp_pkg::q16_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return tpp_pkg::q16_t'($urandom());
    endcase
  endfunction

  // Receiver: random stalls plus an on-demand long hold-off
  always @(negedge clk) begin
    int gap;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else if (hold_off) begin
      out_ch.ready <= 0;
    end else begin
      gap = gap_len();
      out_ch.ready <= (gap == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // Watchdog: cycles without any accept outside a hold-off
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_tri(input tpp_pkg::q16_t c[9]);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y, in_ch.v1_z,
     in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} <= {c[0], c[1], c[2], c[3], c[4], c[5],
                                              c[6], c[7], c[8]};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_random_tri();
    tpp_pkg::q16_t c[9];
    foreach (c[i]) c[i] = rand_coord();
    send_tri(c);
  endtask

  // Wait until all results are back, then let the pipe drain fully
  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input tpp_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [31:0] x, y, z, o, w, h);
    write_reg(tpp_pkg::CFG_X_SCALE, x);
    write_reg(tpp_pkg::CFG_Y_SCALE, y);
    write_reg(tpp_pkg::CFG_Z_SCALE, z);
    write_reg(tpp_pkg::CFG_Z_OFFSET, o);
    write_reg(tpp_pkg::CFG_HALF_WIDTH, w);
    write_reg(tpp_pkg::CFG_HALF_HEIGHT, h);
  endtask

  initial begin
    tpp_pkg::q16_t c[9];
    in_ch.valid = 0;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y, in_ch.v1_z,
     in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    cfg_ch.valid = 0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1;

    // Directed: reset defaults, zero w on each vertex, extremes, saturation
    c = '{32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000, 32'sh0,
          32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001};
    send_tri(c);
    c = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'sh0, -32'sh1};
    send_tri(c);
    c = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    send_tri(c);
    c = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    send_tri(c);
    c = '{32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    send_tri(c);
    c = '{-32'sh1, -32'sh1, -32'sh1, 32'sh1, 32'sh1, 32'sh1, 32'sh5555, -32'sh2, 32'sh3};
    send_tri(c);
    repeat (6) send_random_tri();
    drain();

    // Extreme register settings, out-of-range half sizes, ignored index
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hFFFF_FFFF, 32'h0);
    write_reg(tpp_pkg::cfg_idx_t'(8'hFF), 32'hDEAD_BEEF);
    repeat (8) send_random_tri();
    drain();
    write_all(32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'd4096, 32'd4096);
    repeat (6) send_random_tri();
    drain();

    // Random phases with random or default settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: write_all($urandom_range(32'h8000, 32'h3_0000), $urandom_range(32'h8000, 32'h3_0000),
                     $urandom_range(32'h8000, 32'h2_0000), $urandom(),
                     $urandom_range(0, 4096), $urandom_range(0, 4096));
        1: write_all(32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0, 32'd320, 32'd240);
        default: write_all($urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom());
      endcase
      for (int k = 0; k < 155; k++) begin
        if (ph == 4 && k == 20) begin
          // long receiver hold-off while items keep coming
          fork
            begin
              hold_off = 1;
              repeat (120) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        send_random_tri();
      end
      // sender pause until all results are in
      drain();
    end

    repeat (40) @(negedge clk);
    $display("covered %0d triangles, %0d results, %0d with a zero-w vertex",
             sent, seen_results, seen_zero_w);
    $display("register sweep included extreme scales, offsets and half sizes");
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
